// ===== rtl/rcd_pkg.sv =====
// ----------------------------------------------------------------------------
// rcd_pkg
// Shared constants and request/response types of the rotor cipher decryptor.
// ----------------------------------------------------------------------------
package rcd_pkg;

    localparam int DEF_NUM_ROTORS = 3;
    localparam int ALPHA          = 26;
    localparam int IDX_W          = 5;

    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;
    localparam logic [7:0] CASE_GAP   = 8'h20;

    localparam logic FUNC_LOAD    = 1'b0;
    localparam logic FUNC_DECRYPT = 1'b1;

    typedef struct packed {
        logic             func;
        logic [1:0]       rotor_sel;
        logic [IDX_W-1:0] table_pos;
        logic [IDX_W-1:0] entry_value;
        logic [7:0]       char_in;
    } req_t;

    typedef struct packed {
        logic [7:0] char_out;
        logic       not_found;
    } rsp_t;

    typedef logic [ALPHA-1:0][IDX_W-1:0] row_t;

endpackage

// ===== rtl/rotor_cipher_decrypt.sv =====
// ----------------------------------------------------------------------------
// rotor_cipher_decrypt
// A letter request is searched rotor by rotor in ST_DEC, from the last rotor
// down to rotor 0, and then posted in ST_FIN once the response register is
// free; a non-letter goes straight to ST_FIN, a table load reads and writes
// back its row in ST_LD_WR and gives no response. One request at a time: a
// new request is taken only in ST_IDLE, and an ignored load stays in ST_IDLE.
// Reset clears offsets and control; rotor tables hold nothing until loaded.
// ----------------------------------------------------------------------------
module rotor_cipher_decrypt
    import rcd_pkg::*;
#(
    parameter int NUM_ROTORS = DEF_NUM_ROTORS
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_ready,
    output rsp_t rsp
);

    localparam int ROT_W = (NUM_ROTORS > 1) ? $clog2(NUM_ROTORS) : 1;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_LD_WR = 4'b0010,
        ST_DEC   = 4'b0100,
        ST_FIN   = 4'b1000
    } state_t;

    state_t                         state_reg, state_next;
    logic [ROT_W-1:0]               sel_reg, sel_next;
    logic [IDX_W-1:0]               pos_reg, pos_next;
    logic [IDX_W-1:0]               val_reg, val_next;
    logic [ROT_W-1:0]               rot_reg, rot_next;
    logic [IDX_W-1:0]               idx_reg, idx_next;
    logic [7:0]                     char_reg, char_next;
    logic                           miss_reg, miss_next;
    logic                           letter_reg, letter_next;
    logic [NUM_ROTORS-1:0][IDX_W-1:0] off_reg, off_next;
    logic                           rsp_valid_reg, rsp_valid_next;
    rsp_t                           rsp_reg, rsp_next;

    row_t                           mem [NUM_ROTORS];
    row_t                           rd_row_reg;
    row_t                           wr_row;
    logic                           rd_en;
    logic [ROT_W-1:0]               rd_addr;
    logic                           mem_we;

    logic                           accept;
    logic [7:0]                     ch_fold;
    logic                           is_letter;
    logic                           found;
    logic [IDX_W-1:0]               hit_pos;
    logic [IDX_W:0]                 sum;
    logic [IDX_W-1:0]               nidx;
    logic                           carry;

    assign req_ready = (state_reg == ST_IDLE);
    assign accept    = req_valid && req_ready;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    assign ch_fold   = (req.char_in >= CH_LOWER_A && req.char_in <= CH_LOWER_Z)
                     ? req.char_in - CASE_GAP : req.char_in;
    assign is_letter = (ch_fold >= CH_UPPER_A) && (ch_fold <= CH_UPPER_Z);

    // lowest matching position in the row just read
    always_comb
    begin
        found   = 1'b0;
        hit_pos = '0;
        for (int p = ALPHA - 1; p >= 0; p--)
        begin
            if (rd_row_reg[p] == idx_reg)
            begin
                found   = 1'b1;
                hit_pos = IDX_W'(p);
            end
        end
    end

    assign sum  = {1'b0, hit_pos} + {1'b0, off_reg[rot_reg]};
    assign nidx = (sum >= (IDX_W+1)'(ALPHA)) ? IDX_W'(sum - (IDX_W+1)'(ALPHA))
                                               : IDX_W'(sum);

    always_comb
    begin
        wr_row          = rd_row_reg;
        wr_row[pos_reg] = val_reg;
    end

    always_comb
    begin
        state_next     = state_reg;
        sel_next       = sel_reg;
        pos_next       = pos_reg;
        val_next       = val_reg;
        rot_next       = rot_reg;
        idx_next       = idx_reg;
        char_next      = char_reg;
        miss_next      = miss_reg;
        letter_next    = letter_reg;
        off_next       = off_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg;
        rd_en          = 1'b0;
        rd_addr        = '0;
        mem_we         = 1'b0;
        carry          = 1'b1;

        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (req.func == FUNC_LOAD)
                    begin
                        if (32'(req.rotor_sel) < NUM_ROTORS && 32'(req.table_pos) < ALPHA)
                        begin
                            sel_next   = ROT_W'(req.rotor_sel);
                            pos_next   = req.table_pos;
                            val_next   = req.entry_value;
                            rd_en      = 1'b1;
                            rd_addr    = ROT_W'(req.rotor_sel);
                            state_next = ST_LD_WR;
                        end
                    end
                    else
                    begin
                        miss_next   = 1'b0;
                        letter_next = is_letter;
                        char_next   = ch_fold;
                        if (is_letter)
                        begin
                            idx_next   = IDX_W'(ch_fold - CH_UPPER_A);
                            rot_next   = ROT_W'(NUM_ROTORS - 1);
                            rd_en      = 1'b1;
                            rd_addr    = ROT_W'(NUM_ROTORS - 1);
                            state_next = ST_DEC;
                        end
                        else
                        begin
                            state_next = ST_FIN;
                        end
                    end
                end
            end
            ST_LD_WR:
            begin
                mem_we     = 1'b1;
                state_next = ST_IDLE;
            end
            ST_DEC:
            begin
                miss_next = miss_reg | ~found;
                idx_next  = nidx;
                if (rot_reg == '0)
                begin
                    char_next  = CH_UPPER_A + 8'(nidx);
                    state_next = ST_FIN;
                end
                else
                begin
                    rot_next = rot_reg - ROT_W'(1);
                    rd_en    = 1'b1;
                    rd_addr  = rot_reg - ROT_W'(1);
                end
            end
            ST_FIN:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_next.char_out  = char_reg;
                    rsp_next.not_found = miss_reg;
                    rsp_valid_next     = 1'b1;
                    state_next         = ST_IDLE;
                    // odometer step, rotor 0 fastest
                    if (letter_reg)
                    begin
                        for (int r = 0; r < NUM_ROTORS; r++)
                        begin
                            if (carry)
                            begin
                                if (off_reg[r] == IDX_W'(ALPHA - 1))
                                begin
                                    off_next[r] = '0;
                                end
                                else
                                begin
                                    off_next[r] = off_reg[r] + IDX_W'(1);
                                    carry       = 1'b0;
                                end
                            end
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            off_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            off_reg       <= off_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sel_reg    <= sel_next;
        pos_reg    <= pos_next;
        val_reg    <= val_next;
        rot_reg    <= rot_next;
        idx_reg    <= idx_next;
        char_reg   <= char_next;
        miss_reg   <= miss_next;
        letter_reg <= letter_next;
        rsp_reg    <= rsp_next;
    end

    // rotor row memory
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[sel_reg] <= wr_row;
        end
        if (rd_en)
        begin
            rd_row_reg <= mem[rd_addr];
        end
    end

    a_letter_enters_search: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && req.func == FUNC_DECRYPT && is_letter) |=>
            (state_reg == ST_DEC && rot_reg == ROT_W'(NUM_ROTORS - 1)))
        else $error("letter request did not start the rotor search");

    a_rsp_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg) == ST_FIN)
        else $error("response raised outside finish state");

    a_offsets_step_on_letter: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(off_reg) |-> $past(state_reg == ST_FIN && letter_reg))
        else $error("offsets changed without a letter response");

    a_offset_range: assert property (@(posedge clk) disable iff (!rst_n)
        off_reg[0] < IDX_W'(ALPHA))
        else $error("fast offset out of range");

    a_letter_rsp_upper: assert property (@(posedge clk) disable iff (!rst_n)
        ($rose(rsp_valid_reg) && $past(letter_reg)) |->
            (rsp_reg.char_out >= CH_UPPER_A && rsp_reg.char_out <= CH_UPPER_Z))
        else $error("letter response is not an upper-case letter");

endmodule

// ===== verif/rotor_cipher_decrypt_tb.sv =====
// ----------------------------------------------------------------------------
// rotor_cipher_decrypt_tb
// Self-checking bench for the three-rotor decryptor. The rotor tables are
// loaded in full before any letter is sent. A short directed run covers the
// case folding, the letter borders, ignored loads, missing and repeated
// entries. Random traffic then follows, mostly letters, under several idle
// and stall patterns. A scoreboard keeps its own tables and offsets and
// checks every response against the oldest expected plaintext.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rotor_cipher_decrypt_tb;
    import rcd_pkg::*;

    localparam int ROTORS      = DEF_NUM_ROTORS;
    localparam int STALL_LIMIT = 1000;
    localparam int PHASE_ITEMS = 85;
    localparam int IDLE_PLAN  [4] = '{0, 69, 0, 11};
    localparam int STALL_PLAN [4] = '{0, 0, 69, 11};

    class plaintext_scoreboard;
        logic [IDX_W-1:0] wiring [ROTORS][ALPHA];
        int               offset [ROTORS];
        rsp_t             expected_plain [$];
        int               mismatches;

        function new();
            mismatches = 0;
            foreach (offset[k])
            begin
                offset[k] = 0;
            end
            foreach (wiring[k, p])
            begin
                wiring[k][p] = '0;
            end
        endfunction

        task report(input string what);
            $display("mismatch: %s", what);
            mismatches++;
        endtask

        function bit decipher(input req_t r, output rsp_t o);
            logic [7:0] ch;
            int         idx;
            int         hit;
            int         sum;
            bit         found;
            bit         carry;
            o = '0;
            if (r.func == FUNC_LOAD)
            begin
                if (r.rotor_sel < ROTORS && r.table_pos < ALPHA)
                begin
                    wiring[r.rotor_sel][r.table_pos] = r.entry_value;
                end
                return 1'b0;
            end
            ch = r.char_in;
            if (ch >= CH_LOWER_A && ch <= CH_LOWER_Z)
            begin
                ch = ch - CASE_GAP;
            end
            if (ch >= CH_UPPER_A && ch <= CH_UPPER_Z)
            begin
                idx = ch - CH_UPPER_A;
                for (int k = ROTORS - 1; k >= 0; k--)
                begin
                    found = 1'b0;
                    hit   = 0;
                    for (int p = 0; p < ALPHA; p++)
                    begin
                        if (!found && wiring[k][p] == idx)
                        begin
                            hit   = p;
                            found = 1'b1;
                        end
                    end
                    if (!found)
                    begin
                        o.not_found = 1'b1;
                    end
                    sum = hit + offset[k];
                    if (sum >= ALPHA)
                    begin
                        sum -= ALPHA;
                    end
                    idx = sum;
                end
                ch = CH_UPPER_A + 8'(idx);
                // odometer step, offset 0 fastest
                carry = 1'b1;
                for (int k = 0; k < ROTORS; k++)
                begin
                    if (carry)
                    begin
                        offset[k]++;
                        if (offset[k] >= ALPHA)
                        begin
                            offset[k] = 0;
                        end
                        else
                        begin
                            carry = 1'b0;
                        end
                    end
                end
            end
            o.char_out = ch;
            return 1'b1;
        endfunction

        function void note_request(input req_t r);
            rsp_t o;
            if (decipher(r, o))
            begin
                expected_plain.push_back(o);
            end
        endfunction

        task check_response(input rsp_t got);
            rsp_t want;
            if (expected_plain.size() == 0)
            begin
                report($sformatf("response %h with nothing outstanding", got.char_out));
                return;
            end
            want = expected_plain.pop_front();
            if (got.char_out !== want.char_out)
            begin
                report($sformatf("char_out %h, expected %h", got.char_out, want.char_out));
            end
            if (got.not_found !== want.not_found)
            begin
                report($sformatf("not_found %b, expected %b for char %h",
                                 got.not_found, want.not_found, want.char_out));
            end
        endtask

        function int pending();
            return expected_plain.size();
        endfunction
    endclass

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    logic req_ready;
    req_t req       = '0;
    logic rsp_valid;
    logic rsp_ready = 1'b0;
    rsp_t rsp;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_left      = 0;

    plaintext_scoreboard sb = new();

    rotor_cipher_decrypt #(
        .NUM_ROTORS (ROTORS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_valid && req_ready)
            begin
                sb.note_request(req);
            end
            if (rsp_valid && rsp_ready)
            begin
                sb.check_response(rsp);
            end
        end
    end

    // receiver: long hold-off counted here, otherwise random stalls
    initial
    begin
        logic nxt;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                nxt = 1'b0;
            end
            else
            begin
                nxt = ($urandom_range(99) >= recv_stall_pct);
            end
            @(negedge clk);
            rsp_ready <= nxt;
        end
    end

    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (req_valid && req_ready) || (rsp_valid && rsp_ready))
            begin
                quiet = 0;
            end
            else
            begin
                quiet++;
            end
        end
        $display("TEST FAILED");
        $finish;
    end

    task automatic send_request(input req_t r);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid <= 1'b1;
        req       <= r;
        @(posedge clk);
        while (!req_ready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
    endtask

    task automatic send_load(input logic [1:0] sel, input logic [IDX_W-1:0] pos,
                             input logic [IDX_W-1:0] val);
        req_t r;
        r.func        = FUNC_LOAD;
        r.rotor_sel   = sel;
        r.table_pos   = pos;
        r.entry_value = val;
        r.char_in     = 8'($urandom_range(255));
        send_request(r);
    endtask

    task automatic send_char(input logic [7:0] ch);
        req_t r;
        r.func        = FUNC_DECRYPT;
        r.rotor_sel   = 2'($urandom_range(3));
        r.table_pos   = 5'($urandom_range(31));
        r.entry_value = 5'($urandom_range(31));
        r.char_in     = ch;
        send_request(r);
    endtask

    task automatic reload_rotor(input int k);
        logic [IDX_W-1:0] perm [ALPHA];
        logic [IDX_W-1:0] t;
        int               j;
        for (int i = 0; i < ALPHA; i++)
        begin
            perm[i] = 5'(i);
        end
        for (int i = ALPHA - 1; i > 0; i--)
        begin
            j       = $urandom_range(i);
            t       = perm[i];
            perm[i] = perm[j];
            perm[j] = t;
        end
        for (int p = 0; p < ALPHA; p++)
        begin
            send_load(2'(k), 5'(p), perm[p]);
        end
    endtask

    task automatic drain();
        req_valid <= 1'b0;
        while (sb.pending() != 0)
        begin
            @(negedge clk);
        end
        // a trailing load may still be in flight
        repeat (8) @(negedge clk);
    endtask

    initial
    begin
        int          sent;
        int          pick;
        logic [7:0]  ch;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // every entry written before the first letter
        for (int k = 0; k < ROTORS; k++)
        begin
            for (int p = 0; p < ALPHA; p++)
            begin
                send_load(2'(k), 5'(p), 5'((p + 7 * k + 3) % ALPHA));
            end
        end

        // ignored loads
        send_load(2'd3, 5'd5, 5'd9);
        send_load(2'd0, 5'd26, 5'd1);
        send_load(2'd1, 5'd31, 5'd31);

        send_char("A");
        send_char("Z");
        send_char("a");
        send_char("z");
        send_char(8'h40);
        send_char(8'h5B);
        send_char(8'h60);
        send_char(8'h7B);
        send_char(8'h00);
        send_char(8'hFF);

        // letter missing from the last rotor
        send_load(2'd2, 5'd0, 5'd31);
        send_char("R");
        send_char("r");
        // repeated entry in the middle rotor, lowest position wins
        send_load(2'd1, 5'd25, 5'd10);
        send_char("K");
        send_char("J");
        send_char("b");
        // out-of-range value in the first rotor
        send_load(2'd0, 5'd25, 5'd26);
        send_char("C");
        send_char("x");

        for (int ph = 0; ph < 4; ph++)
        begin
            send_idle_pct  = IDLE_PLAN[ph];
            recv_stall_pct = STALL_PLAN[ph];
            if (ph == 0)
            begin
                hold_left = 60;
            end
            sent = 0;
            while (sent < PHASE_ITEMS)
            begin
                pick = $urandom_range(99);
                if (pick < 70)
                begin
                    ch = ($urandom_range(1) != 0) ? CH_LOWER_A : CH_UPPER_A;
                    send_char(ch + 8'($urandom_range(ALPHA - 1)));
                    sent++;
                end
                else if (pick < 80)
                begin
                    send_char(8'($urandom_range(255)));
                    sent++;
                end
                else if (pick < 93)
                begin
                    send_load(2'($urandom_range(ROTORS - 1)), 5'($urandom_range(ALPHA - 1)),
                              ($urandom_range(9) == 0) ? 5'($urandom_range(31, ALPHA))
                                                       : 5'($urandom_range(ALPHA - 1)));
                    sent++;
                end
                else if (pick < 97)
                begin
                    if ($urandom_range(1) != 0)
                    begin
                        send_load(2'd3, 5'($urandom_range(31)), 5'($urandom_range(31)));
                    end
                    else
                    begin
                        send_load(2'($urandom_range(3)), 5'($urandom_range(31, ALPHA)),
                                  5'($urandom_range(31)));
                    end
                end
                else
                begin
                    reload_rotor($urandom_range(ROTORS - 1));
                    sent += ALPHA;
                end
            end
            drain();
        end

        repeat (20) @(posedge clk);
        if (sb.pending() != 0)
        begin
            sb.report($sformatf("%0d responses never arrived", sb.pending()));
        end
        if (sb.mismatches == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
